FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high
`define SPF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spf assertion failed");

// Clocked property that is also checked through reset
`define SPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spf assertion failed");

`endif

FILE: rtl/core/spf_pkg.sv
// Shared types, constants and the CRC step function for the packet framer
package spf_pkg;

  // Header bytes and CRC polynomial
  localparam logic [7:0]  HDR_SYNC = 8'hFF;
  localparam logic [7:0]  HDR_MARK = 8'hFD;
  localparam logic [7:0]  HDR_RSVD = 8'h00;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // One queued body word with its framing marks
  typedef struct packed {
    logic [7:0]  body;
    logic [7:0]  id;
    logic [15:0] len;
    logic        first;
    logic        last;
  } spf_item_t;

  // Non-reflected CRC-16 over one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/spf_front.sv
// Input side: takes body words and holds them in a short queue for the emitter
module spf_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        body_byte,
  input  logic [7:0]        target_id,
  input  logic [15:0]       packet_length,
  input  logic              first_byte,
  input  logic              last_byte,
  input  logic              pop,
  output logic              head_valid,
  output spf_pkg::spf_item_t head
);
  import spf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  spf_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  spf_item_t       item;

  // Pack the incoming word; the first mark selects header emission downstream
  always_comb begin
    item.body  = body_byte;
    item.id    = target_id;
    item.len   = packet_length;
    item.first = first_byte;
    item.last  = last_byte;
  end

  assign in_stall   = (count == CW'(DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/spf_back.sv
// Emitter: walks header, body and CRC bytes of the head word into the output register
module spf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  spf_pkg::spf_item_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               packet_end
);
  import spf_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_ID, PH_LEN_LO, PH_LEN_HI,
    PH_BODY, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t      phase;
  phase_t      cur;
  phase_t      phase_next;
  logic        mid;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_base;
  logic [7:0]  byte_sel;
  logic        fin;
  logic        fire;

  // Current phase: carried on mid-word, else picked from the first mark
  always_comb begin
    cur = mid ? phase : (head.first ? PH_HDR0 : PH_BODY);
  end

  // Byte select and next phase
  always_comb begin
    byte_sel   = head.body;
    phase_next = PH_BODY;
    unique case (cur)
      PH_HDR0:   begin byte_sel = HDR_SYNC;        phase_next = PH_HDR1;   end
      PH_HDR1:   begin byte_sel = HDR_SYNC;        phase_next = PH_HDR2;   end
      PH_HDR2:   begin byte_sel = HDR_MARK;        phase_next = PH_HDR3;   end
      PH_HDR3:   begin byte_sel = HDR_RSVD;        phase_next = PH_ID;     end
      PH_ID:     begin byte_sel = head.id;         phase_next = PH_LEN_LO; end
      PH_LEN_LO: begin byte_sel = head.len[7:0];   phase_next = PH_LEN_HI; end
      PH_LEN_HI: begin byte_sel = head.len[15:8];  phase_next = PH_BODY;   end
      PH_BODY:   begin byte_sel = head.body;       phase_next = PH_CRC_LO; end
      PH_CRC_LO: begin byte_sel = crc[7:0];        phase_next = PH_CRC_HI; end
      PH_CRC_HI: begin byte_sel = crc[15:8];       phase_next = PH_BODY;   end
      default:   begin byte_sel = head.body;       phase_next = PH_BODY;   end
    endcase
  end

  // CRC update: restart on the header, hold over CRC low, clear after CRC high
  always_comb begin
    crc_base = (cur == PH_HDR0) ? '0 : crc;
    unique case (cur)
      PH_CRC_LO: crc_next = crc;
      PH_CRC_HI: crc_next = '0;
      default:   crc_next = crc_feed(crc_base, byte_sel);
    endcase
  end

  assign fin  = ((cur == PH_BODY) && !head.last) || (cur == PH_CRC_HI);
  assign fire = head_valid && (!out_valid || !out_stall);
  assign pop  = fire && fin;

  // Phase, CRC and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BODY;
      mid       <= 1'b0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        crc        <= crc_next;
        mid        <= !fin;
        phase      <= phase_next;
        out_valid  <= 1'b1;
        out_byte   <= byte_sel;
        run_last   <= fin;
        packet_end <= (cur == PH_CRC_HI);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/servo_packet_framer_crc16_unit.sv
// Top level of the servo-bus packet framer with CRC-16
//
//  channel | handshake           | word
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_stall | body_byte, target_id, packet_length, first/last_byte
//  out     | out_valid/out_stall | out_byte, run_last, packet_end
//
// A first word is led by the header bytes, a last word followed by the two CRC
// bytes. The output register sets the rate, one byte per cycle while out_stall
// is low; a queue of QUEUE_DEPTH words lets input keep flowing during bursts.
// in_stall is high only while the queue is full. Reset clears the queue, the CRC
// and the output valid. Output stalls hold the byte and back up into the queue.
module servo_packet_framer_crc16_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  body_byte,
  input  logic [7:0]  target_id,
  input  logic [15:0] packet_length,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        packet_end
);
  import spf_pkg::*;

  spf_item_t head;
  logic      head_valid;
  logic      pop;

  // Intake and queue
  spf_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .body_byte     (body_byte),
    .target_id     (target_id),
    .packet_length (packet_length),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .pop           (pop),
    .head_valid    (head_valid),
    .head          (head)
  );

  // Byte emitter and CRC
  spf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .packet_end (packet_end)
  );

endmodule

FILE: rtl/core/spf_checker.sv
// Port-level checks for the packet framer, bound to the top level
`include "assert_macros.svh"

module spf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        run_last,
  input logic        packet_end
);

  // A stalled output word stays offered
  `SPF_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  // The closing CRC byte is always the last byte of its input word
  `SPF_ASSERT(a_end_is_last, clk, rst, out_valid && packet_end |-> run_last)

  // Two closing bytes never follow back to back: a CRC low byte sits between
  `SPF_ASSERT(a_end_spacing, clk, rst, out_valid && !out_stall && packet_end |=> !(out_valid && packet_end))

  // Nothing is offered in the cycle after reset
  `SPF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid)

endmodule

bind servo_packet_framer_crc16_unit spf_checker u_spf_checker (.*);
